// ----- rtl/qu8a_pkg.sv -----
`timescale 1ns / 1ps

package qu8a_pkg;

  localparam int VAL_W      = 8;
  localparam int MUL_W      = 16;
  localparam int I16_W      = 16;
  localparam int ZP_SUM_W   = I16_W + 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIRST_ZERO_POINT  = 3'd0,
    REG_FIRST_MULTIPLIER  = 3'd1,
    REG_SECOND_ZERO_POINT = 3'd2,
    REG_SECOND_MULTIPLIER = 3'd3,
    REG_RESULT_ZERO_POINT = 3'd4,
    REG_RESULT_FLOOR      = 3'd5,
    REG_RESULT_CEILING    = 3'd6
  } qu8a_reg_t;

  typedef struct packed {
    logic        [VAL_W-1:0] first_zero_point;
    logic signed [MUL_W-1:0] first_multiplier;
    logic        [VAL_W-1:0] second_zero_point;
    logic signed [MUL_W-1:0] second_multiplier;
    logic        [VAL_W-1:0] result_zero_point;
    logic        [VAL_W-1:0] result_floor;
    logic        [VAL_W-1:0] result_ceiling;
  } qu8a_cfg_t;

endpackage

// ----- rtl/qu8a_in_if.sv -----
`timescale 1ns / 1ps

interface qu8a_in_if;
  logic                       valid;
  logic                       ready;
  logic [qu8a_pkg::VAL_W-1:0] first_value;
  logic [qu8a_pkg::VAL_W-1:0] second_value;

  modport source (output valid, output first_value, output second_value, input ready);
  modport sink (input valid, input first_value, input second_value, output ready);
endinterface

// ----- rtl/qu8a_out_if.sv -----
`timescale 1ns / 1ps

interface qu8a_out_if;
  logic                       valid;
  logic                       ready;
  logic [qu8a_pkg::VAL_W-1:0] sum_value;

  modport source (output valid, output sum_value, input ready);
  modport sink (input valid, input sum_value, output ready);
endinterface

// ----- rtl/qu8a_cfg_if.sv -----
`timescale 1ns / 1ps

interface qu8a_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [qu8a_pkg::CFG_IDX_W-1:0]  index;
  logic [qu8a_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/qu8a_cfg_regs.sv -----
`timescale 1ns / 1ps

module qu8a_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  qu8a_cfg_if.sink            cfg_chan,
  output qu8a_pkg::qu8a_cfg_t cfg
);
  import qu8a_pkg::*;

  qu8a_cfg_t cfg_r;
  qu8a_cfg_t cfg_nxt;

  assign cfg_chan.ready = 1'b1;
  assign cfg            = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        REG_FIRST_ZERO_POINT:  cfg_nxt.first_zero_point  = cfg_chan.data[VAL_W-1:0];
        REG_FIRST_MULTIPLIER:  cfg_nxt.first_multiplier  = $signed(cfg_chan.data[MUL_W-1:0]);
        REG_SECOND_ZERO_POINT: cfg_nxt.second_zero_point = cfg_chan.data[VAL_W-1:0];
        REG_SECOND_MULTIPLIER: cfg_nxt.second_multiplier = $signed(cfg_chan.data[MUL_W-1:0]);
        REG_RESULT_ZERO_POINT: cfg_nxt.result_zero_point = cfg_chan.data[VAL_W-1:0];
        REG_RESULT_FLOOR:      cfg_nxt.result_floor      = cfg_chan.data[VAL_W-1:0];
        REG_RESULT_CEILING:    cfg_nxt.result_ceiling    = cfg_chan.data[VAL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.first_zero_point  <= '0;
      cfg_r.first_multiplier  <= '0;
      cfg_r.second_zero_point <= '0;
      cfg_r.second_multiplier <= '0;
      cfg_r.result_zero_point <= '0;
      cfg_r.result_floor      <= '0;
      cfg_r.result_ceiling    <= '1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- rtl/qu8a_scale.sv -----
`timescale 1ns / 1ps

module qu8a_scale #(
  parameter int  INPUT_SHIFT = 6,
  localparam int PROD_W      = qu8a_pkg::VAL_W + 1 + INPUT_SHIFT + qu8a_pkg::MUL_W
) (
  input  logic                     clk,
  input  logic                     rst_n,
  qu8a_in_if.sink                  in_chan,
  input  qu8a_pkg::qu8a_cfg_t      cfg,
  output logic                     prod_valid,
  input  logic                     prod_ready,
  output logic signed [PROD_W-1:0] prod_first,
  output logic signed [PROD_W-1:0] prod_second
);
  import qu8a_pkg::*;

  localparam int DIFF_W = VAL_W + 1;
  localparam int SHL_W  = DIFF_W + INPUT_SHIFT;

  logic                     s1_valid_r;
  logic [VAL_W-1:0]         first_r;
  logic [VAL_W-1:0]         second_r;
  logic                     s1_ready;
  logic                     prod_valid_r;
  logic signed [PROD_W-1:0] prod_first_r;
  logic signed [PROD_W-1:0] prod_second_r;
  logic signed [PROD_W-1:0] prod_first_nxt;
  logic signed [PROD_W-1:0] prod_second_nxt;

  function automatic logic signed [PROD_W-1:0] scale_term(
    input logic        [VAL_W-1:0] value,
    input logic        [VAL_W-1:0] zero,
    input logic signed [MUL_W-1:0] mul
  );
    logic signed [DIFF_W-1:0] diff;
    logic signed [SHL_W-1:0]  shifted;
    logic signed [PROD_W-1:0] prod;
    diff    = $signed({1'b0, value}) - $signed({1'b0, zero});
    shifted = SHL_W'(diff) <<< INPUT_SHIFT;
    prod    = shifted * mul;
    return prod;
  endfunction

  assign s1_ready      = !prod_valid_r || prod_ready;
  assign in_chan.ready = !s1_valid_r || s1_ready;

  assign prod_first_nxt  = scale_term(first_r, cfg.first_zero_point, cfg.first_multiplier);
  assign prod_second_nxt = scale_term(second_r, cfg.second_zero_point, cfg.second_multiplier);

  assign prod_valid  = prod_valid_r;
  assign prod_first  = prod_first_r;
  assign prod_second = prod_second_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      prod_valid_r <= 1'b0;
    end else begin
      if (in_chan.ready) begin
        s1_valid_r <= in_chan.valid;
      end
      if (s1_ready) begin
        prod_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      first_r  <= in_chan.first_value;
      second_r <= in_chan.second_value;
    end
    if (s1_valid_r && s1_ready) begin
      prod_first_r  <= prod_first_nxt;
      prod_second_r <= prod_second_nxt;
    end
  end

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> s1_valid_r)
    else $error("accepted item did not reach the input register");

  a_stalled_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_ready |=> s1_valid_r && $stable(first_r) && $stable(second_r))
    else $error("stalled item in the input register was lost or changed");

  a_zero_mul_zero_prod: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_ready && cfg.first_multiplier == '0 |=> prod_first_r == '0)
    else $error("product with a zero multiplier is not zero");

endmodule

// ----- rtl/qu8a_requant.sv -----
`timescale 1ns / 1ps

module qu8a_requant #(
  parameter int  INPUT_SHIFT  = 6,
  parameter int  RESULT_SHIFT = 16,
  localparam int PROD_W       = qu8a_pkg::VAL_W + 1 + INPUT_SHIFT + qu8a_pkg::MUL_W
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     prod_valid,
  output logic                     prod_ready,
  input  logic signed [PROD_W-1:0] prod_first,
  input  logic signed [PROD_W-1:0] prod_second,
  input  qu8a_pkg::qu8a_cfg_t      cfg,
  qu8a_out_if.source               out_chan
);
  import qu8a_pkg::*;

  localparam int SUM_W = PROD_W + 1;
  localparam int RND_W = ((SUM_W > RESULT_SHIFT) ? SUM_W : RESULT_SHIFT) + 2;
  localparam logic signed [RND_W-1:0] HALF    = RND_W'(1) << (RESULT_SHIFT - 1);
  localparam logic signed [RND_W-1:0] I16_MAX = RND_W'(32767);
  localparam logic signed [RND_W-1:0] I16_MIN = RND_W'(-32768);
  localparam logic signed [ZP_SUM_W-1:0] U8_MAX = ZP_SUM_W'(255);

  logic                       out_valid_r;
  logic [VAL_W-1:0]           sum_value_r;
  logic [VAL_W-1:0]           sum_value_nxt;
  logic signed [SUM_W-1:0]    sum;
  logic signed [RND_W-1:0]    rounded;
  logic signed [RND_W-1:0]    shifted;
  logic signed [I16_W-1:0]    sat16;
  logic signed [ZP_SUM_W-1:0] with_zp;
  logic [VAL_W-1:0]           clipped;
  logic [VAL_W-1:0]           floored;

  assign prod_ready = !out_valid_r || out_chan.ready;

  always_comb begin
    sum     = SUM_W'(prod_first) + SUM_W'(prod_second);
    rounded = RND_W'(sum) + HALF;
    shifted = rounded >>> RESULT_SHIFT;
    if (shifted > I16_MAX) begin
      sat16 = I16_W'(I16_MAX);
    end else if (shifted < I16_MIN) begin
      sat16 = I16_W'(I16_MIN);
    end else begin
      sat16 = shifted[I16_W-1:0];
    end
    with_zp = ZP_SUM_W'(sat16) + $signed(ZP_SUM_W'(cfg.result_zero_point));
    if (with_zp < 0) begin
      clipped = '0;
    end else if (with_zp > U8_MAX) begin
      clipped = '1;
    end else begin
      clipped = with_zp[VAL_W-1:0];
    end
    floored       = (clipped < cfg.result_floor) ? cfg.result_floor : clipped;
    sum_value_nxt = (floored > cfg.result_ceiling) ? cfg.result_ceiling : floored;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (prod_ready) begin
      out_valid_r <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_valid && prod_ready) begin
      sum_value_r <= sum_value_nxt;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.sum_value = sum_value_r;

  a_within_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && cfg.result_floor <= cfg.result_ceiling |->
      sum_value_r >= cfg.result_floor && sum_value_r <= cfg.result_ceiling)
    else $error("result outside the configured range");

  a_crossed_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && cfg.result_floor > cfg.result_ceiling |->
      sum_value_r == cfg.result_ceiling)
    else $error("crossed bounds did not give the ceiling");

  a_stalled_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_chan.ready |=> out_valid_r && $stable(sum_value_r))
    else $error("stalled result was lost or changed");

endmodule

// ----- rtl/quantized_u8_add.sv -----
`timescale 1ns / 1ps

// Quantized uint8 elementwise add, one item per clock cycle sustained while results are
// taken. Each item passes an input register, a product register holding the two scaled
// operands, and a result register. Ready travels back through the three registers in the
// same cycle, so a full pipeline keeps taking items while the result is taken.
// Configuration writes are taken every cycle and are meant for an idle block.
module quantized_u8_add #(
  parameter int INPUT_SHIFT  = 6,
  parameter int RESULT_SHIFT = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  qu8a_in_if.sink     in_chan,
  qu8a_out_if.source  out_chan,
  qu8a_cfg_if.sink    cfg_chan
);
  import qu8a_pkg::*;

  localparam int PROD_W = VAL_W + 1 + INPUT_SHIFT + MUL_W;

  qu8a_cfg_t                cfg;
  logic                     prod_valid;
  logic                     prod_ready;
  logic signed [PROD_W-1:0] prod_first;
  logic signed [PROD_W-1:0] prod_second;

  qu8a_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .cfg      (cfg)
  );

  qu8a_scale #(
    .INPUT_SHIFT (INPUT_SHIFT)
  ) u_scale (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .cfg         (cfg),
    .prod_valid  (prod_valid),
    .prod_ready  (prod_ready),
    .prod_first  (prod_first),
    .prod_second (prod_second)
  );

  qu8a_requant #(
    .INPUT_SHIFT  (INPUT_SHIFT),
    .RESULT_SHIFT (RESULT_SHIFT)
  ) u_requant (
    .clk         (clk),
    .rst_n       (rst_n),
    .prod_valid  (prod_valid),
    .prod_ready  (prod_ready),
    .prod_first  (prod_first),
    .prod_second (prod_second),
    .cfg         (cfg),
    .out_chan    (out_chan)
  );

endmodule
